@@ sv/coolant_sensor_ratiometric_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// coolant sensor filter assertion macros
// Shared property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COOLANT_SENSOR_RATIOMETRIC_FILTER_UNIT_ASSERT_SVH
`define COOLANT_SENSOR_RATIOMETRIC_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSRF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csrf same-cycle check failed");

// next-cycle implication, checked out of reset
`define CSRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csrf next-cycle check failed");

`endif

@@ sv/csrf_pkg.sv @@
// ----------------------------------------------------------------------------
// csrf_pkg
// Types and constants shared by the coolant sensor filter modules.
// ----------------------------------------------------------------------------
package csrf_pkg;

  // sample and register width
  localparam int unsigned DataW = 10;
  localparam int unsigned ProdW = 2 * DataW;

  // block averaging
  localparam int unsigned BlockSamples    = 8;
  localparam int unsigned FirstBlockStart = 4;
  localparam int unsigned IdxW            = $clog2(BlockSamples);
  localparam int unsigned WidxW           = 4;
  localparam int unsigned AccW            = DataW + IdxW;
  localparam int unsigned FullShift       = $clog2(BlockSamples);
  localparam int unsigned FirstShift      = $clog2(BlockSamples - FirstBlockStart);

  localparam logic [DataW-1:0] AdMax    = 10'd1023;
  localparam logic [WidxW-1:0] IdxEmpty = 4'd15;
  localparam logic [WidxW-1:0] IdxLast  = WidxW'(BlockSamples - 1);

  // register reset values
  localparam logic [DataW-1:0] RefOkThrRst = 10'd819;
  localparam logic [DataW-1:0] RefDiffRst  = 10'd205;
  localparam logic [DataW-1:0] RefScaleRst = 10'd1016;
  localparam logic [DataW-1:0] EnterLowRst = 10'd40;
  localparam logic [DataW-1:0] LeaveLowRst = 10'd45;

  // stream widths
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned InTdataW   = 40;
  localparam int unsigned OutTdataW  = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_OK_THR = 3'd0,
    CFG_REF_DIFF   = 3'd1,
    CFG_REF_SCALE  = 3'd2,
    CFG_ENTER_LOW  = 3'd3,
    CFG_LEAVE_LOW  = 3'd4
  } cfg_reg_e;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic             ref_ok;
    logic [DataW-1:0] ref_after;
    logic [DataW-1:0] ref_before;
    logic             sensor_ok;
    logic [DataW-1:0] sensor_sample;
    logic             restart;
    logic             ign_on;
  } in_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_CLAMP,
    ST_DIV,
    ST_STORE,
    ST_SUM,
    ST_CMP,
    ST_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_init;
    logic div_step;
    logic store;
    logic sum_step;
    logic cmp;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sample_ok;
    logic div_last;
    logic block_end;
    logic sum_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/csrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// csrf_ctrl
// Sequencer for one tick: check, multiply, serial divide, store, block sum, compare, output.
// ----------------------------------------------------------------------------
module csrf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  csrf_pkg::dp_status_t status_i,
  output csrf_pkg::dp_cmd_t    cmd_o
);
  import csrf_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.sample_ok ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = status_i.block_end ? ST_SUM : ST_DONE;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.sum_last) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/csrf_dp.sv @@
// ----------------------------------------------------------------------------
// csrf_dp
// Registers, reference check, ratiometric divider, sample ring, block
// averager, hysteresis comparator and output register.
// ----------------------------------------------------------------------------
module csrf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  csrf_pkg::in_item_t                 item_i,
  input  logic                               cfg_valid_i,
  input  logic [csrf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [csrf_pkg::DataW-1:0]         cfg_data_i,
  input  csrf_pkg::dp_cmd_t                  cmd_i,
  output csrf_pkg::dp_status_t               status_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic                               m_flag_o
);
  import csrf_pkg::*;

  // configuration registers
  logic [DataW-1:0] thr_q, lim_q, scale_q, enter_q, leave_q;

  // filter state
  logic [WidxW-1:0] widx_q;
  logic             primed_q;
  logic             range_q;
  logic [DataW-1:0] store_q [BlockSamples];

  // per-tick working registers
  in_item_t         in_q;
  logic [ProdW-1:0] prod_q;
  logic [DataW-1:0] mean_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] lo_q;
  logic [DataW-1:0] quo_q;
  logic             clamp_q;
  logic [3:0]       dcnt_q;
  logic [IdxW-1:0]  sidx_q;
  logic [AccW-1:0]  acc_q;
  logic             m_valid_q;
  logic             m_flag_q;

  // reference check
  logic [DataW-1:0] ref_diff;
  logic             sample_ok;
  logic             clear;
  logic [DataW:0]   ref_sum;

  always_comb begin
    ref_diff = (in_q.ref_before >= in_q.ref_after) ?
               (in_q.ref_before - in_q.ref_after) :
               (in_q.ref_after - in_q.ref_before);
    sample_ok = in_q.ign_on & in_q.sensor_ok & in_q.ref_ok &
                (in_q.ref_before >= thr_q) & (in_q.ref_after >= thr_q) &
                (ref_diff < lim_q);
    clear   = cmd_i.eval & (in_q.restart | ~in_q.ign_on);
    ref_sum = {1'b0, in_q.ref_before} + {1'b0, in_q.ref_after};
  end

  // one restoring division step
  logic [DataW:0] div_r;
  logic [DataW:0] div_sub;
  logic           div_ge;

  always_comb begin
    div_r   = {rem_q, lo_q[DataW-1]};
    div_ge  = div_r >= {1'b0, mean_q};
    div_sub = div_r - {1'b0, mean_q};
  end

  // ring slot for the next accepted sample
  logic [WidxW-1:0] widx_nx;
  logic [DataW-1:0] corr;

  always_comb begin
    widx_nx = (widx_q >= IdxLast) ? '0 : widx_q + WidxW'(1);
    corr    = clamp_q ? AdMax : quo_q;
  end

  // block average
  logic [DataW-1:0] avg;

  always_comb begin
    avg = primed_q ? acc_q[FullShift +: DataW] : acc_q[FirstShift +: DataW];
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= RefOkThrRst;
      lim_q     <= RefDiffRst;
      scale_q   <= RefScaleRst;
      enter_q   <= EnterLowRst;
      leave_q   <= LeaveLowRst;
      widx_q    <= IdxEmpty;
      primed_q  <= 1'b0;
      range_q   <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_REF_OK_THR: thr_q   <= cfg_data_i;
          CFG_REF_DIFF:   lim_q   <= cfg_data_i;
          CFG_REF_SCALE:  scale_q <= cfg_data_i;
          CFG_ENTER_LOW:  enter_q <= cfg_data_i;
          CFG_LEAVE_LOW:  leave_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (clear) begin
        widx_q   <= IdxEmpty;
        primed_q <= 1'b0;
        range_q  <= 1'b1;
      end
      if (cmd_i.store) begin
        widx_q <= widx_nx;
      end
      // hysteresis, tested against the current range only
      if (cmd_i.cmp) begin
        primed_q <= 1'b1;
        if (range_q) begin
          if (avg < enter_q) begin
            range_q <= 1'b0;
          end
        end else begin
          if (avg > leave_q) begin
            range_q <= 1'b1;
          end
        end
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= item_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(in_q.sensor_sample) * ProdW'(scale_q);
      mean_q <= ref_sum[DataW:1];
    end
    // a zero mean always clamps
    if (cmd_i.div_init) begin
      clamp_q <= prod_q >= {mean_q, {DataW{1'b0}}};
      rem_q   <= prod_q[ProdW-1:DataW];
      lo_q    <= prod_q[DataW-1:0];
      quo_q   <= '0;
      dcnt_q  <= 4'(DataW - 1);
    end
    if (cmd_i.div_step) begin
      rem_q  <= div_ge ? div_sub[DataW-1:0] : div_r[DataW-1:0];
      lo_q   <= {lo_q[DataW-2:0], 1'b0};
      quo_q  <= {quo_q[DataW-2:0], div_ge};
      dcnt_q <= dcnt_q - 4'd1;
    end
    if (cmd_i.store) begin
      store_q[widx_nx[IdxW-1:0]] <= corr;
      sidx_q <= primed_q ? '0 : IdxW'(FirstBlockStart);
      acc_q  <= '0;
    end
    if (cmd_i.sum_step) begin
      acc_q  <= acc_q + AccW'(store_q[sidx_q]);
      sidx_q <= sidx_q + IdxW'(1);
    end
    if (cmd_i.out_load) begin
      m_flag_q <= ~range_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.sample_ok = sample_ok;
    status_o.div_last  = dcnt_q == 4'd0;
    status_o.block_end = widx_nx == IdxLast;
    status_o.sum_last  = sidx_q == IdxW'(BlockSamples - 1);
    status_o.out_free  = ~m_valid_q | m_ready_i;
  end

  assign m_valid_o = m_valid_q;
  assign m_flag_o  = m_flag_q;

endmodule

@@ sv/coolant_sensor_ratiometric_filter_unit.sv @@
// ----------------------------------------------------------------------------
// coolant_sensor_ratiometric_filter_unit
// Ratiometric coolant sample filter with block averaging and a two-range
// hysteresis comparator; one low-range flag per tick.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready one tick of sensor readings
// m_axis    out  m_axis_tvalid/m_axis_tready low_range_flag
// cfg       in   cfg_valid_i/cfg_ready_o     register index and value
//
// A rejected tick or ignition off goes from the check straight to the result.
// An accepted sample is multiplied, then run through the serial divider (10 steps) and stored.
// A tick that closes a block adds the ring sum over 4 or 8 slots, then the compare step.
// rst_ni clears the comparator and ring index and restores register defaults.
// A result waits in the output register while the next tick is taken.
// ----------------------------------------------------------------------------
`include "coolant_sensor_ratiometric_filter_unit_assert.svh"

module coolant_sensor_ratiometric_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: ign_on, restart, sensor_sample[9:0], sensor_ok, ref_before[9:0],
  //        ref_after[9:0], ref_ok, zero fill
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [csrf_pkg::InTdataW-1:0]     s_axis_tdata,
  // tdata: low_range_flag, zero fill
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [csrf_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csrf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [csrf_pkg::DataW-1:0]        cfg_data_i
);
  import csrf_pkg::*;

  in_item_t   item;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       flag;

  assign item        = in_item_t'(s_axis_tdata);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata = {{(OutTdataW - 1){1'b0}}, flag};

  // sequencer
  csrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  csrf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_flag_o    (flag)
  );

  // checks
  `CSRF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CSRF_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready)
  `CSRF_ASSERT_NOW(a_one_command, 1'b1, $onehot0(cmd))

endmodule

@@ sim/coolant_sensor_ratiometric_filter_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coolant_sensor_ratiometric_filter_unit_test
// Self-checking bench for the coolant sensor filter. Ticks go in on the
// input stream, an in-bench predictor of the ratiometric correction, the
// block averaging and the range comparator computes each low-range flag, and
// every flag on the output stream is checked in order. Register settings move
// from the reset values through extremes, crossed limits and reject-all cases.
// ----------------------------------------------------------------------------
module coolant_sensor_ratiometric_filter_unit_test;
  import csrf_pkg::*;

  localparam int unsigned RegCount      = 5;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportMax     = 10;
  localparam int unsigned MaxGap        = 6;
  localparam int unsigned MaxBurst      = 24;
  localparam int unsigned MaxStallRun   = 12;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_mode_e;

  // dut ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InTdataW-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [DataW-1:0]      cfg_data_i    = '0;

  // predictor copy of the registers
  logic [DataW-1:0] thr_lim;
  logic [DataW-1:0] ref_gap_max;
  logic [DataW-1:0] scale_num;
  logic [DataW-1:0] enter_lim;
  logic [DataW-1:0] leave_lim;

  // predictor copy of the filter state
  logic [DataW-1:0] avg_ring [BlockSamples];
  logic [WidxW-1:0] ring_slot;
  logic             ring_primed;
  logic             upper_range;

  // flags still owed by the dut, oldest first
  logic pending_flags [$];

  // traffic shaping
  stall_mode_e stall_mode  = STALL_NONE;
  bit          gaps_on     = 1'b0;
  int unsigned burst_left  = 0;
  int unsigned stall_run   = 0;
  logic        stall_level = 1'b1;
  int unsigned level_target = 0;
  int unsigned level_left   = 0;

  // bookkeeping
  int unsigned fault_count   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned flags_checked = 0;
  int unsigned range_flips   = 0;
  int unsigned cfg_writes    = 0;
  int unsigned block_closes  = 0;
  int unsigned idle_cycles   = 0;

  coolant_sensor_ratiometric_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_filter();
    foreach (avg_ring[i]) avg_ring[i] = '0;
    ring_slot   = IdxEmpty;
    ring_primed = 1'b0;
    upper_range = 1'b1;
  endfunction

  // one tick in, the low-range flag it leaves behind out
  function automatic logic predict_low_range(input in_item_t t);
    int unsigned rb, ra, gap, mean, quot, total, first, count;
    logic [DataW-1:0] corr;
    logic was_upper;
    begin
      was_upper = upper_range;
      rb = t.ref_before;
      ra = t.ref_after;
      gap = (rb < ra) ? (ra - rb) : (rb - ra);
      if (t.restart) clear_filter();
      if (!t.ign_on) begin
        clear_filter();
      end else if (t.sensor_ok && t.ref_ok && rb >= thr_lim && ra >= thr_lim &&
                   gap < ref_gap_max) begin
        // ratiometric correction, a zero mean saturates
        mean = (rb + ra) >> 1;
        if (mean == 0) begin
          corr = AdMax;
        end else begin
          quot = (int'(t.sensor_sample) * int'(scale_num)) / mean;
          corr = (quot > AdMax) ? AdMax : quot[DataW-1:0];
        end
        ring_slot = (ring_slot >= IdxLast) ? '0 : ring_slot + 1'b1;
        avg_ring[ring_slot[IdxW-1:0]] = corr;
        // block end: average and run the comparator
        if (ring_slot >= IdxLast) begin
          first = ring_primed ? 0 : FirstBlockStart;
          count = BlockSamples - first;
          total = 0;
          for (int i = first; i < BlockSamples; i++) total += avg_ring[i];
          total = total / count;
          ring_primed = 1'b1;
          block_closes++;
          if (upper_range) begin
            if (total < enter_lim) upper_range = 1'b0;
          end else if (total > leave_lim) begin
            upper_range = 1'b1;
          end
        end
      end
      if (was_upper != upper_range) range_flips++;
      return !upper_range;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall pattern, checker, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    case (stall_mode)
      STALL_NONE: begin
        m_axis_tready <= 1'b1;
      end
      STALL_RANDOM: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_level = $urandom_range(0, 1);
          stall_run   = $urandom_range(1, MaxStallRun);
        end
        stall_run--;
        m_axis_tready <= stall_level;
      end
    endcase
  end

  task automatic note_fault(input string what, input logic want, input logic got);
    fault_count++;
    if (fault_count <= ReportMax)
      $display("%0t: %s low_range_flag expected %0b got %0b", $time, what, want, got);
  endtask

  // compare each flag transaction with the oldest prediction
  always @(posedge clk_i) begin : flag_check
    logic want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_flags.size() == 0) begin
        note_fault("unexpected transaction,", 1'bx, m_axis_tdata[0]);
      end else begin
        want = pending_flags.pop_front();
        flags_checked++;
        if (m_axis_tdata[0] !== want) note_fault("mismatch,", want, m_axis_tdata[0]);
      end
    end
  end

  // ends a run that stops moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_tick(input logic ign, input logic rst,
                                       input int unsigned raw, input logic sok,
                                       input int unsigned rb, input int unsigned ra,
                                       input logic rok);
    in_item_t t;
    begin
      t               = '0;
      t.ign_on        = ign;
      t.restart       = rst;
      t.sensor_sample = raw[DataW-1:0];
      t.sensor_ok     = sok;
      t.ref_before    = rb[DataW-1:0];
      t.ref_after     = ra[DataW-1:0];
      t.ref_ok        = rok;
      return t;
    end
  endfunction

  // drives one tick; with gaps on, bursts are broken up by random gaps
  task automatic send_tick(input in_item_t t);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
      burst_left = $urandom_range(1, MaxBurst);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tdata  <= t;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_flags.push_back(predict_low_range(t));
    ticks_sent++;
  endtask

  // mostly sound ticks with averages steered around the range limits
  function automatic in_item_t random_tick();
    in_item_t t;
    int unsigned rb, ra, span, lo, hi, mean, raw;
    begin
      if (level_left == 0) begin
        case ($urandom_range(0, 3))
          0: level_target = (enter_lim > 3) ? enter_lim - 3 : 0;
          1: level_target = (leave_lim < AdMax - 3) ? leave_lim + 3 : AdMax;
          2: level_target = $urandom_range(0, AdMax);
          default: level_target = $urandom_range(0, 1) ? enter_lim : leave_lim;
        endcase
        level_left = $urandom_range(8, 12);
      end
      level_left--;
      if ($urandom_range(0, 99) < 85) begin
        rb   = $urandom_range(AdMax, thr_lim);
        span = (ref_gap_max == 0) ? 0 : ref_gap_max - 1;
        hi   = (rb + span > AdMax) ? AdMax : rb + span;
        lo   = (rb > thr_lim + span) ? rb - span : thr_lim;
        ra   = $urandom_range(hi, lo);
      end else begin
        rb = $urandom_range(0, AdMax);
        ra = $urandom_range(0, AdMax);
      end
      mean = (rb + ra) >> 1;
      if ($urandom_range(0, 99) < 65 && scale_num != 0) begin
        raw = (level_target * mean) / scale_num + $urandom_range(0, 4);
        if (raw >= 2) raw -= 2;
        if (raw > AdMax) raw = AdMax;
      end else begin
        raw = $urandom_range(0, AdMax);
      end
      t = mk_tick($urandom_range(0, 99) >= 2, $urandom_range(0, 99) < 2, raw,
                  $urandom_range(0, 99) >= 4, rb, ra, $urandom_range(0, 99) >= 4);
      return t;
    end
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_tick(random_tick());
  endtask

  // waits until every flag is back and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_flags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      CFG_REF_OK_THR: thr_lim     = val;
      CFG_REF_DIFF:   ref_gap_max = val;
      CFG_REF_SCALE:  scale_num   = val;
      CFG_ENTER_LOW:  enter_lim   = val;
      CFG_LEAVE_LOW:  leave_lim   = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned gap,
                                input int unsigned scale, input int unsigned enter,
                                input int unsigned leave);
    settle();
    write_reg(CFG_REF_OK_THR, thr[DataW-1:0]);
    write_reg(CFG_REF_DIFF, gap[DataW-1:0]);
    write_reg(CFG_REF_SCALE, scale[DataW-1:0]);
    write_reg(CFG_ENTER_LOW, enter[DataW-1:0]);
    write_reg(CFG_LEAVE_LOW, leave[DataW-1:0]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset values: rejects, clamp, first block into range zero and back out
  task automatic test_reset_defaults();
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    send_tick(mk_tick(1'b0, 1'b0, AdMax, 1'b1, 1016, 1016, 1'b1));
    send_tick(mk_tick(1'b1, 1'b1, 0, 1'b1, 1016, 1016, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 500, 1'b0, 1016, 1016, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 500, 1'b1, 1016, 1016, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 500, 1'b1, 818, 900, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 5, 1'b1, 819, AdMax, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, AdMax, 1'b1, AdMax, 819, 1'b1));
    repeat (5) send_tick(mk_tick(1'b1, 1'b0, 10, 1'b1, 1016, 1016, 1'b1));
    repeat (8) send_tick(mk_tick(1'b1, 1'b0, AdMax, 1'b1, 819, 819, 1'b1));
    send_tick(mk_tick(1'b1, 1'b1, 20, 1'b1, 1016, 1016, 1'b1));
    send_tick(mk_tick(1'b0, 1'b1, 20, 1'b1, 1016, 1016, 1'b1));
  endtask

  task automatic test_default_traffic();
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    run_random(340);
  endtask

  // open window, zero reference mean saturates, limits at opposite ends
  task automatic test_extreme_limits();
    apply_settings(0, AdMax, AdMax, AdMax, 0);
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    send_tick(mk_tick(1'b1, 1'b1, 0, 1'b1, 0, 0, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, AdMax, 1'b1, 0, 1, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, AdMax, 1'b1, 1, 2, 1'b1));
    repeat (5) send_tick(mk_tick(1'b1, 1'b0, 0, 1'b1, 0, 0, 1'b1));
    run_random(150);
  endtask

  // narrowest window and zero scale
  task automatic test_reject_all_window();
    apply_settings(AdMax, 1, 0, 1, AdMax);
    gaps_on    = 1'b1;
    stall_mode = STALL_BURSTY;
    repeat (8) send_tick(mk_tick(1'b1, 1'b0, AdMax, 1'b1, AdMax, AdMax, 1'b1));
    run_random(100);
    // zero difference limit rejects every sample; spare indexes change nothing
    apply_settings(500, 0, 700, 300, 600);
    for (int i = RegCount; i < (1 << CfgIdxW); i++) write_reg(i[CfgIdxW-1:0], '1);
    cfg_valid_i <= 1'b0;
    run_random(60);
  endtask

  // threshold and difference limit at their edges
  task automatic test_reference_window();
    apply_settings(600, 300, 900, 200, 260);
    gaps_on    = 1'b1;
    stall_mode = STALL_BURSTY;
    send_tick(mk_tick(1'b1, 1'b1, 100, 1'b1, 700, 1000, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 100, 1'b1, 700, 999, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 100, 1'b1, 599, 650, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 100, 1'b1, 600, 650, 1'b1));
    run_random(350);
  endtask

  // enter limit above the leave limit
  task automatic test_crossed_limits();
    apply_settings(700, 150, 1016, 500, 100);
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    run_random(300);
  endtask

  initial begin
    thr_lim     = RefOkThrRst;
    ref_gap_max = RefDiffRst;
    scale_num   = RefScaleRst;
    enter_lim   = EnterLowRst;
    leave_lim   = LeaveLowRst;
    clear_filter();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_default_traffic();
    test_extreme_limits();
    test_reject_all_window();
    test_reference_window();
    test_crossed_limits();
    settle();

    $display("%0d ticks sent, %0d flags checked, %0d blocks closed, %0d range changes",
             ticks_sent, flags_checked, block_closes, range_flips);
    $display("%0d register writes over six settings, %0d faults", cfg_writes,
             fault_count);
    if (fault_count == 0 && pending_flags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/csrf_pkg.sv
sv/csrf_ctrl.sv
sv/csrf_dp.sv
sv/coolant_sensor_ratiometric_filter_unit.sv
sim/coolant_sensor_ratiometric_filter_unit_test.sv
